// File: rtl/core/lgrs_pkg.sv
package lgrs_pkg;

	// Board geometry
	localparam int MAX_WIDTH = 64;
	localparam int ROW_W     = 64;
	localparam int WIDTH_W   = 7;
	localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(MAX_WIDTH);

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH = REG_IDX_W'(0);

	// Result queue
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef struct packed {
		logic             frame_last;
		logic [ROW_W-1:0] row_cells;
	} row_item_t;

	typedef struct packed {
		logic             frame_end;
		logic [ROW_W-1:0] next_row;
	} res_item_t;

	// Masked bits one cell shows its neighbors
	typedef struct packed {
		logic above;
		logic middle;
		logic fresh;
	} col_bits_t;

	// Row-wide control fanned out to every cell
	typedef struct packed {
		logic load;
		logic have_middle;
		logic last;
	} cell_ctrl_t;

	// B3/S23
	function automatic logic life_rule(input logic [3:0] n, input logic alive);
		life_rule = (n == 4'd3) || (alive && (n == 4'd2));
	endfunction

endpackage

// File: rtl/core/lgrs_cell.sv
module lgrs_cell import lgrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       en,
	input  logic       row_bit,
	input  col_bits_t  left,
	input  col_bits_t  right,
	output col_bits_t  self_bits,
	output logic       res_up,
	output logic       res_low
);

	logic       above_q;
	logic       middle_q;
	logic [3:0] n_up;
	logic [3:0] n_low;
	logic       up_mid;

	// Column bits masked by the width currently in force
	assign self_bits.above  = above_q & en;
	assign self_bits.middle = middle_q & en;
	assign self_bits.fresh  = row_bit & en;

	// Held middle row released with the new row below it
	assign n_up = 4'(left.above) + 4'(self_bits.above) + 4'(right.above)
		+ 4'(left.middle) + 4'(right.middle)
		+ 4'(left.fresh) + 4'(self_bits.fresh) + 4'(right.fresh);
	assign res_up = en & life_rule(n_up, self_bits.middle);

	// Bottom row: held middle above, dead row below
	assign up_mid = ctrl.have_middle;
	assign n_low = (up_mid ? (4'(left.middle) + 4'(self_bits.middle) + 4'(right.middle))
		: 4'd0) + 4'(left.fresh) + 4'(right.fresh);
	assign res_low = en & life_rule(n_low, self_bits.fresh);

	// Shift the window down one row on each transfer; a bottom-row transfer clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctrl.load) begin
			if (ctrl.last) begin
				above_q  <= 1'b0;
				middle_q <= 1'b0;
			end else begin
				above_q  <= ctrl.have_middle & self_bits.middle;
				middle_q <= self_bits.fresh;
			end
		end
	end

endmodule

// File: rtl/core/lgrs_res_queue.sv
module lgrs_res_queue import lgrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_a,
	input  res_item_t item_a,
	input  logic      push_b,
	input  res_item_t item_b,
	output logic      space,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	res_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_PTR_W-1:0] b_ptr;
	logic                  pop;

	// Room for the two results one row can release
	assign space     = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign res_valid = count_q != '0;
	assign res_data  = mem_q[rd_ptr_q];
	assign pop       = res_valid & res_ready;
	assign b_ptr     = wr_ptr_q + FIFO_PTR_W'(push_a);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= item_a;
		end
		if (push_b) begin
			mem_q[b_ptr] <= item_b;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q  <= count_q + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
				- FIFO_CNT_W'(pop);
		end
	end

endmodule

// File: rtl/core/life_generation_row_stream_unit.sv
// Conway Life (B3/S23) row stream, one generation per pass over the board.
// Row channel (row_valid/row_ready/row_data): the current generation enters
// top row first, one 64-bit row per transfer; frame_last marks the bottom row.
// Result channel (res_valid/res_ready/res_data): next-generation rows leave in
// board order. A row transfer releases the result for the row above it into
// the result queue. The bottom row releases that result and then its own, marked
// frame_end, computed with a dead row below. A one-row frame gives one result.
// Throughput: one row per cycle. The chain of 64 column cells evaluates both
// candidate results in the cycle of the transfer; a four-entry result queue
// absorbs the extra result of a bottom row, so row_ready stays high as long as
// the receiver drains one result per cycle on average.
// When the receiver stalls, rows keep flowing until the queue holds more than
// two results; row_ready then drops until results are taken.
// APB register 0 (row_width, 7 bits): columns at or beyond it are dead; 0 acts
// as 1. Write it only while the block is idle. pready is always high.
// Reset: held rows clear (frame restarts), result queue empties, row_width
// returns to 64.
module life_generation_row_stream_unit import lgrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_ready,
	input  row_item_t          row_data,
	output logic               res_valid,
	input  logic               res_ready,
	output res_item_t          res_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [WIDTH_W-1:0]   row_width_q;
	logic [WIDTH_W-1:0]   eff_w;
	logic [MAX_WIDTH-1:0] en;
	logic                 have_middle_q;
	logic                 accept;
	logic                 reg_hit;
	cell_ctrl_t           ctrl;
	col_bits_t            cb [MAX_WIDTH];
	logic [ROW_W-1:0]     res_up_v;
	logic [ROW_W-1:0]     res_low_v;
	res_item_t            item_a;
	res_item_t            item_b;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_ROW_WIDTH;
	assign prdata  = reg_hit ? PDATA_W'(row_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			row_width_q <= pwdata[WIDTH_W-1:0];
		end
	end

	// Column enables from the clamped width
	always_comb begin
		if (row_width_q == '0) begin
			eff_w = WIDTH_W'(1);
		end else if (row_width_q > WIDTH_W'(MAX_WIDTH)) begin
			eff_w = WIDTH_W'(MAX_WIDTH);
		end else begin
			eff_w = row_width_q;
		end
		for (int c = 0; c < MAX_WIDTH; c++) begin
			en[c] = WIDTH_W'(c) < eff_w;
		end
	end

	// Frame tracking
	assign accept = row_valid & row_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_middle_q <= 1'b0;
		end else if (accept) begin
			have_middle_q <= !row_data.frame_last;
		end
	end

	assign ctrl.load        = accept;
	assign ctrl.have_middle = have_middle_q;
	assign ctrl.last        = row_data.frame_last;

	// Chain of column cells, dead beyond both edges
	for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
		col_bits_t left_n;
		col_bits_t right_n;

		if (c == 0) begin : g_l_edge
			assign left_n = '0;
		end else begin : g_l_mid
			assign left_n = cb[c-1];
		end
		if (c == MAX_WIDTH - 1) begin : g_r_edge
			assign right_n = '0;
		end else begin : g_r_mid
			assign right_n = cb[c+1];
		end

		lgrs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.en        (en[c]),
			.row_bit   (row_data.row_cells[c]),
			.left      (left_n),
			.right     (right_n),
			.self_bits (cb[c]),
			.res_up    (res_up_v[c]),
			.res_low   (res_low_v[c])
		);
	end

	if (MAX_WIDTH < ROW_W) begin : g_pad
		assign res_up_v[ROW_W-1:MAX_WIDTH]  = '0;
		assign res_low_v[ROW_W-1:MAX_WIDTH] = '0;
	end

	// Results into the queue, released row first
	assign item_a.frame_end = 1'b0;
	assign item_a.next_row  = res_up_v;
	assign item_b.frame_end = 1'b1;
	assign item_b.next_row  = res_low_v;

	lgrs_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (accept & have_middle_q),
		.item_a    (item_a),
		.push_b    (accept & row_data.frame_last),
		.item_b    (item_b),
		.space     (row_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// File: rtl/core/lgrs_checker.sv
module lgrs_checker import lgrs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               row_valid,
	input logic               row_ready,
	input row_item_t          row_data,
	input logic               res_valid,
	input logic               res_ready,
	input res_item_t          res_data,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// A bottom-row transfer always leaves a result to show
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && row_data.frame_last |=> res_valid)
		else $error("bottom row released no result");

	// Register read-back never shows bits past the width field
	a_prdata_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[PDATA_W-1:WIDTH_W] == '0)
		else $error("prdata upper bits set");

	// Zero-wait port
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low");

endmodule

bind life_generation_row_stream_unit lgrs_checker u_lgrs_checker (.*);
